// ----- hdl/rrts_pkg.sv -----
// Shared types and constants for the round-robin task scheduler.
// Used by every module of the block; depends on nothing.
package rrts_pkg;

   localparam int NUM_SLOTS   = 16;
   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int PORT_SLOT_W = 4;
   localparam int KIND_W      = 3;
   localparam int PID_W       = 16;
   localparam int TICK_W      = 32;
   localparam int MS_W        = 32;
   localparam int DIVR_W      = 10;
   localparam int STAT_W      = 2;
   localparam int WOKEN_W     = 5;
   localparam int DSTEP_W     = $clog2(MS_W);

   localparam logic [DIVR_W-1:0] MS_PER_TICK_RST = DIVR_W'(10);
   localparam logic [PID_W-1:0]  PID_FIRST       = PID_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC      = 3'd0,
      KIND_FREE       = 3'd1,
      KIND_ADD_READY  = 3'd2,
      KIND_DISPATCH   = 3'd3,
      KIND_YIELD      = 3'd4,
      KIND_SLEEP      = 3'd5,
      KIND_WAKE_CHECK = 3'd6
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      RES_DONE = 2'd0,
      RES_NONE = 2'd1,
      RES_FULL = 2'd2
   } result_code_type;

   typedef enum logic [1:0] {
      SLOT_FREE     = 2'd0,
      SLOT_READY    = 2'd1,
      SLOT_RUNNING  = 2'd2,
      SLOT_SLEEPING = 2'd3
   } slot_state_type;

   typedef enum logic [2:0] {
      ADDR_IDX,
      ADDR_REQ,
      ADDR_RUN,
      ADDR_RDY,
      ADDR_SLP
   } addr_sel_type;

   typedef enum logic [1:0] {
      PID_KEEP,
      PID_NEXT,
      PID_ZERO
   } pid_sel_type;

   typedef enum logic [1:0] {
      WAKE_KEEP,
      WAKE_ZERO,
      WAKE_CALC
   } wake_sel_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_A_ADDR,
      S_A_READ,
      S_A_CHECK,
      S_F_READ,
      S_F_WRITE,
      S_R_READ,
      S_R_WRITE,
      S_D_POP,
      S_D_READ,
      S_D_WRITE,
      S_Y_READ,
      S_Y_CHECK,
      S_S_DIV,
      S_S_READ,
      S_S_WRITE,
      S_W_POP,
      S_W_READ,
      S_W_CHECK,
      S_FINISH
   } fsm_state_type;

   typedef struct packed {
      slot_state_type    state;
      logic [PID_W-1:0]  pid;
      logic [TICK_W-1:0] wake;
   } slot_entry_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic           ld_req;
      logic           res_clr;
      logic           res_done;
      logic           res_full;
      logic           res_slot;
      logic           res_alloc;
      logic           woken_inc;
      logic           addr_ld;
      addr_sel_type   addr_sel;
      logic           idx_clr;
      logic           idx_inc;
      logic           tbl_rd;
      logic           tbl_wr;
      slot_state_type wr_status;
      pid_sel_type    wr_pid;
      wake_sel_type   wr_wake;
      logic           nid_inc;
      logic           rdy_push;
      logic           rdy_pop;
      logic           slp_push;
      logic           slp_pop;
      logic           run_set;
      logic           run_clr;
      logic           div_start;
      logic           div_step;
      logic           n_ld;
      logic           n_dec;
      logic           out_ld;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              slot_ok;
      logic              rdy_empty;
      logic              rdy_full;
      logic              slp_empty;
      logic              slp_full;
      logic              run_valid;
      logic              q_free;
      logic              q_running;
      logic              q_due;
      logic              idx_last;
      logic              n_last;
      logic              div_last;
   } dp_stat_type;

endpackage

// ----- hdl/rrts_fifo.sv -----
// Slot-number queue: circular buffer with head pointer and fill count.
// Depends on rrts_pkg for widths and depth.
module rrts_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic                       pop,
   input  logic [rrts_pkg::SLOT_W-1:0] wr_data,
   output logic [rrts_pkg::SLOT_W-1:0] rd_data,
   output logic [rrts_pkg::CNT_W-1:0]  count,
   output logic                       empty,
   output logic                       full
);

   logic [rrts_pkg::SLOT_W-1:0] mem [rrts_pkg::NUM_SLOTS];
   logic [rrts_pkg::SLOT_W-1:0] head_ff, head_in;
   logic [rrts_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [rrts_pkg::SLOT_W-1:0] tail;
   logic [rrts_pkg::SLOT_W-1:0] rd_q_ff;

   // Tail sits count entries past head, modulo depth
   assign tail  = head_ff + count_ff[rrts_pkg::SLOT_W-1:0];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == rrts_pkg::CNT_W'(rrts_pkg::NUM_SLOTS));
   assign count = count_ff;
   assign rd_data = rd_q_ff;

   // Advance pointers
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop) begin
         head_in  = head_ff + rrts_pkg::SLOT_W'(1);
         count_in = count_ff - rrts_pkg::CNT_W'(1);
      end else if (push) begin
         count_in = count_ff + rrts_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Write at tail, read head every cycle
   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail] <= wr_data;
      end
      rd_q_ff <= mem[head_ff];
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(push && pop))
      else $error("push and pop in the same cycle");

endmodule

// ----- hdl/rrts_div.sv -----
// Restoring divider, one quotient bit per cycle while step is high, for the sleep tick count.
// Depends on rrts_pkg for widths.
module rrts_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        step,
   input  logic [rrts_pkg::MS_W-1:0]   dividend,
   input  logic [rrts_pkg::DIVR_W-1:0] divisor,
   output logic [rrts_pkg::MS_W-1:0]   quotient,
   output logic                        rem_nonzero,
   output logic                        last
);

   logic [rrts_pkg::MS_W-1:0]    quo_ff;
   logic [rrts_pkg::DIVR_W-1:0]  rem_ff;
   logic [rrts_pkg::DIVR_W-1:0]  den_ff;
   logic [rrts_pkg::DSTEP_W-1:0] cnt_ff;
   logic [rrts_pkg::DIVR_W:0]    trial;
   logic [rrts_pkg::DIVR_W:0]    diff;
   logic                         fits;

   // Shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, quo_ff[rrts_pkg::MS_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   assign quotient    = quo_ff;
   assign rem_nonzero = (rem_ff != '0);
   assign last        = (cnt_ff == rrts_pkg::DSTEP_W'(rrts_pkg::MS_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= '0;
      end else if (step) begin
         cnt_ff <= cnt_ff + rrts_pkg::DSTEP_W'(1);
      end
   end

   // Zero tick length divides as one
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= (divisor == '0) ? rrts_pkg::DIVR_W'(1) : divisor;
      end else if (step) begin
         quo_ff <= {quo_ff[rrts_pkg::MS_W-2:0], fits};
         rem_ff <= fits ? diff[rrts_pkg::DIVR_W-1:0] : trial[rrts_pkg::DIVR_W-1:0];
      end
   end

endmodule

// ----- hdl/rrts_datapath.sv -----
// Scheduler datapath: slot table, queues, running task, divider, results.
// Depends on rrts_pkg, rrts_fifo and rrts_div.
module rrts_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  rrts_pkg::dp_cmd_type             cmd,
   output rrts_pkg::dp_stat_type            stat,
   input  logic [rrts_pkg::KIND_W-1:0]      req_kind,
   input  logic [rrts_pkg::PORT_SLOT_W-1:0] req_slot,
   input  logic [rrts_pkg::MS_W-1:0]        req_milliseconds,
   input  logic [rrts_pkg::TICK_W-1:0]      req_now,
   input  logic                             csr_wr_en,
   input  logic [rrts_pkg::DIVR_W-1:0]      csr_wr_data,
   output logic [rrts_pkg::STAT_W-1:0]      rsp_status,
   output logic [rrts_pkg::PORT_SLOT_W-1:0] rsp_result_slot,
   output logic [rrts_pkg::PID_W-1:0]       rsp_result_pid,
   output logic                             rsp_running_valid,
   output logic [rrts_pkg::PORT_SLOT_W-1:0] rsp_running_slot,
   output logic [rrts_pkg::WOKEN_W-1:0]     rsp_woken_count
);

   // Captured item
   logic [rrts_pkg::KIND_W-1:0]      kind_ff;
   logic [rrts_pkg::PORT_SLOT_W-1:0] slot_ff;
   logic [rrts_pkg::MS_W-1:0]        ms_ff;
   logic [rrts_pkg::TICK_W-1:0]      now_ff;

   logic [rrts_pkg::DIVR_W-1:0]      ms_per_tick_ff;
   logic [rrts_pkg::SLOT_W-1:0]      addr_ff, addr_in;
   logic [rrts_pkg::SLOT_W-1:0]      idx_ff;
   logic [rrts_pkg::CNT_W-1:0]       n_ff;
   logic [rrts_pkg::PID_W-1:0]       nid_ff;
   logic                             run_valid_ff;
   logic [rrts_pkg::SLOT_W-1:0]      run_slot_ff;

   // Slot table
   rrts_pkg::slot_entry_type         tbl_mem [rrts_pkg::NUM_SLOTS];
   logic [rrts_pkg::NUM_SLOTS-1:0]   tbl_vld_ff;
   rrts_pkg::slot_entry_type         tbl_q_ff;
   rrts_pkg::slot_entry_type         wr_entry;

   // Result and output registers
   logic [rrts_pkg::STAT_W-1:0]      res_status_ff;
   logic [rrts_pkg::PORT_SLOT_W-1:0] res_slot_ff;
   logic [rrts_pkg::PID_W-1:0]       res_pid_ff;
   logic [rrts_pkg::WOKEN_W-1:0]     woken_ff;
   logic [rrts_pkg::STAT_W-1:0]      out_status_ff;
   logic [rrts_pkg::PORT_SLOT_W-1:0] out_slot_ff;
   logic [rrts_pkg::PID_W-1:0]       out_pid_ff;
   logic                             out_run_valid_ff;
   logic [rrts_pkg::PORT_SLOT_W-1:0] out_run_slot_ff;
   logic [rrts_pkg::WOKEN_W-1:0]     out_woken_ff;

   logic [rrts_pkg::SLOT_W-1:0]      rdy_head;
   logic [rrts_pkg::SLOT_W-1:0]      slp_head;
   logic [rrts_pkg::CNT_W-1:0]       rdy_count;
   logic [rrts_pkg::CNT_W-1:0]       slp_count;
   logic                             rdy_empty, rdy_full, slp_empty, slp_full;

   logic [rrts_pkg::MS_W-1:0]        quotient;
   logic                             rem_nz;
   logic                             div_last;
   logic [rrts_pkg::TICK_W:0]        wake_sum;
   logic [rrts_pkg::TICK_W-1:0]      wake_calc;

   rrts_fifo u_ready_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd.rdy_push),
      .pop     (cmd.rdy_pop),
      .wr_data (addr_ff),
      .rd_data (rdy_head),
      .count   (rdy_count),
      .empty   (rdy_empty),
      .full    (rdy_full)
   );

   rrts_fifo u_sleep_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd.slp_push),
      .pop     (cmd.slp_pop),
      .wr_data (addr_ff),
      .rd_data (slp_head),
      .count   (slp_count),
      .empty   (slp_empty),
      .full    (slp_full)
   );

   rrts_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .step        (cmd.div_step),
      .dividend    (ms_ff),
      .divisor     (ms_per_tick_ff),
      .quotient    (quotient),
      .rem_nonzero (rem_nz),
      .last        (div_last)
   );

   // Wake tick: now plus rounded-up quotient, saturated
   assign wake_sum  = {1'b0, now_ff} + {1'b0, quotient}
                      + (rrts_pkg::TICK_W + 1)'(rem_nz);
   assign wake_calc = wake_sum[rrts_pkg::TICK_W] ? '1 : wake_sum[rrts_pkg::TICK_W-1:0];

   // Capture item and tick length
   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         kind_ff <= req_kind;
         slot_ff <= req_slot;
         ms_ff   <= req_milliseconds;
         now_ff  <= req_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_per_tick_ff <= rrts_pkg::MS_PER_TICK_RST;
      end else if (csr_wr_en) begin
         ms_per_tick_ff <= csr_wr_data;
      end
   end

   // Select the slot address
   always_comb begin
      unique case (cmd.addr_sel)
         rrts_pkg::ADDR_IDX: addr_in = idx_ff;
         rrts_pkg::ADDR_REQ: addr_in = rrts_pkg::SLOT_W'(slot_ff);
         rrts_pkg::ADDR_RUN: addr_in = run_slot_ff;
         rrts_pkg::ADDR_RDY: addr_in = rdy_head;
         rrts_pkg::ADDR_SLP: addr_in = slp_head;
         default:            addr_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.addr_ld) begin
         addr_ff <= addr_in;
      end
   end

   // Scan index and sleeper count
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         n_ff   <= '0;
      end else begin
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + rrts_pkg::SLOT_W'(1);
         end
         if (cmd.n_ld) begin
            n_ff <= slp_count;
         end else if (cmd.n_dec) begin
            n_ff <= n_ff - rrts_pkg::CNT_W'(1);
         end
      end
   end

   // Next process id and running task
   always_ff @(posedge clock) begin
      if (reset) begin
         nid_ff       <= rrts_pkg::PID_FIRST;
         run_valid_ff <= 1'b0;
         run_slot_ff  <= '0;
      end else begin
         if (cmd.nid_inc) begin
            nid_ff <= nid_ff + rrts_pkg::PID_W'(1);
         end
         if (cmd.run_set) begin
            run_valid_ff <= 1'b1;
            run_slot_ff  <= addr_ff;
         end else if (cmd.run_clr) begin
            run_valid_ff <= 1'b0;
            run_slot_ff  <= '0;
         end
      end
   end

   // Build the table entry to write
   always_comb begin
      wr_entry       = tbl_q_ff;
      wr_entry.state = cmd.wr_status;
      unique case (cmd.wr_pid)
         rrts_pkg::PID_NEXT: wr_entry.pid = nid_ff;
         rrts_pkg::PID_ZERO: wr_entry.pid = '0;
         default:            wr_entry.pid = tbl_q_ff.pid;
      endcase
      unique case (cmd.wr_wake)
         rrts_pkg::WAKE_ZERO: wr_entry.wake = '0;
         rrts_pkg::WAKE_CALC: wr_entry.wake = wake_calc;
         default:             wr_entry.wake = tbl_q_ff.wake;
      endcase
   end

   // Entries never written read as free, pid zero, wake zero
   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_vld_ff <= '0;
      end else if (cmd.tbl_wr) begin
         tbl_vld_ff[addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_wr) begin
         tbl_mem[addr_ff] <= wr_entry;
      end
      if (cmd.tbl_rd) begin
         tbl_q_ff <= tbl_vld_ff[addr_ff] ? tbl_mem[addr_ff] : '0;
      end
   end

   // Accumulate the result of the item
   always_ff @(posedge clock) begin
      if (cmd.res_clr) begin
         res_status_ff <= rrts_pkg::RES_NONE;
         res_slot_ff   <= '0;
         res_pid_ff    <= '0;
         woken_ff      <= '0;
      end else begin
         if (cmd.res_full) begin
            res_status_ff <= rrts_pkg::RES_FULL;
         end else if (cmd.res_done) begin
            res_status_ff <= rrts_pkg::RES_DONE;
         end
         if (cmd.res_alloc) begin
            res_slot_ff <= rrts_pkg::PORT_SLOT_W'(addr_ff);
            res_pid_ff  <= nid_ff;
         end else if (cmd.res_slot) begin
            res_slot_ff <= rrts_pkg::PORT_SLOT_W'(addr_ff);
            res_pid_ff  <= tbl_q_ff.pid;
         end
         if (cmd.woken_inc) begin
            woken_ff <= woken_ff + rrts_pkg::WOKEN_W'(1);
         end
      end
   end

   // Hold the finished item for the result channel
   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         out_status_ff    <= res_status_ff;
         out_slot_ff      <= res_slot_ff;
         out_pid_ff       <= res_pid_ff;
         out_run_valid_ff <= run_valid_ff;
         out_run_slot_ff  <= rrts_pkg::PORT_SLOT_W'(run_slot_ff);
         out_woken_ff     <= woken_ff;
      end
   end

   assign rsp_status        = out_status_ff;
   assign rsp_result_slot   = out_slot_ff;
   assign rsp_result_pid    = out_pid_ff;
   assign rsp_running_valid = out_run_valid_ff;
   assign rsp_running_slot  = out_run_slot_ff;
   assign rsp_woken_count   = out_woken_ff;

   // Status to the controller
   always_comb begin
      stat.kind      = kind_ff;
      stat.slot_ok   = (32'(slot_ff) < rrts_pkg::NUM_SLOTS);
      stat.rdy_empty = rdy_empty;
      stat.rdy_full  = rdy_full;
      stat.slp_empty = slp_empty;
      stat.slp_full  = slp_full;
      stat.run_valid = run_valid_ff;
      stat.q_free    = (tbl_q_ff.state == rrts_pkg::SLOT_FREE);
      stat.q_running = (tbl_q_ff.state == rrts_pkg::SLOT_RUNNING);
      stat.q_due     = (now_ff >= tbl_q_ff.wake);
      stat.idx_last  = (idx_ff == rrts_pkg::SLOT_W'(rrts_pkg::NUM_SLOTS - 1));
      stat.n_last    = (n_ff == rrts_pkg::CNT_W'(1));
      stat.div_last  = div_last;
   end

endmodule

// ----- hdl/rrts_ctrl.sv -----
// Scheduler controller: sequences each command over the datapath.
// Depends on rrts_pkg for the state, command and status types.
module rrts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rrts_pkg::dp_stat_type stat,
   output rrts_pkg::dp_cmd_type  cmd
);

   rrts_pkg::fsm_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;
   logic                    accept;

   assign req_ready = (state_ff == rrts_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrts_pkg::S_IDLE: begin
            if (accept) state_in = rrts_pkg::S_DECODE;
         end
         rrts_pkg::S_DECODE: begin
            unique case (stat.kind)
               rrts_pkg::KIND_ALLOC:
                  state_in = rrts_pkg::S_A_ADDR;
               rrts_pkg::KIND_FREE:
                  state_in = stat.slot_ok ? rrts_pkg::S_F_READ : rrts_pkg::S_FINISH;
               rrts_pkg::KIND_ADD_READY:
                  state_in = (stat.slot_ok && !stat.rdy_full) ? rrts_pkg::S_R_READ
                                                              : rrts_pkg::S_FINISH;
               rrts_pkg::KIND_DISPATCH:
                  state_in = !stat.rdy_empty ? rrts_pkg::S_D_POP : rrts_pkg::S_FINISH;
               rrts_pkg::KIND_YIELD:
                  state_in = stat.run_valid ? rrts_pkg::S_Y_READ : rrts_pkg::S_FINISH;
               rrts_pkg::KIND_SLEEP:
                  state_in = (stat.run_valid && !stat.slp_full) ? rrts_pkg::S_S_DIV
                                                                : rrts_pkg::S_FINISH;
               rrts_pkg::KIND_WAKE_CHECK:
                  state_in = !stat.slp_empty ? rrts_pkg::S_W_POP : rrts_pkg::S_FINISH;
               default:
                  state_in = rrts_pkg::S_FINISH;
            endcase
         end
         rrts_pkg::S_A_ADDR:  state_in = rrts_pkg::S_A_READ;
         rrts_pkg::S_A_READ:  state_in = rrts_pkg::S_A_CHECK;
         rrts_pkg::S_A_CHECK: begin
            if (stat.q_free || stat.idx_last) state_in = rrts_pkg::S_FINISH;
            else                              state_in = rrts_pkg::S_A_ADDR;
         end
         rrts_pkg::S_F_READ:  state_in = rrts_pkg::S_F_WRITE;
         rrts_pkg::S_F_WRITE: state_in = rrts_pkg::S_FINISH;
         rrts_pkg::S_R_READ:  state_in = rrts_pkg::S_R_WRITE;
         rrts_pkg::S_R_WRITE: state_in = rrts_pkg::S_FINISH;
         rrts_pkg::S_D_POP:   state_in = rrts_pkg::S_D_READ;
         rrts_pkg::S_D_READ:  state_in = rrts_pkg::S_D_WRITE;
         rrts_pkg::S_D_WRITE: state_in = rrts_pkg::S_FINISH;
         rrts_pkg::S_Y_READ:  state_in = rrts_pkg::S_Y_CHECK;
         rrts_pkg::S_Y_CHECK: state_in = rrts_pkg::S_FINISH;
         rrts_pkg::S_S_DIV: begin
            if (stat.div_last) state_in = rrts_pkg::S_S_READ;
         end
         rrts_pkg::S_S_READ:  state_in = rrts_pkg::S_S_WRITE;
         rrts_pkg::S_S_WRITE: begin
            state_in = stat.rdy_empty ? rrts_pkg::S_FINISH : rrts_pkg::S_D_POP;
         end
         rrts_pkg::S_W_POP:   state_in = rrts_pkg::S_W_READ;
         rrts_pkg::S_W_READ:  state_in = rrts_pkg::S_W_CHECK;
         rrts_pkg::S_W_CHECK: begin
            state_in = stat.n_last ? rrts_pkg::S_FINISH : rrts_pkg::S_W_POP;
         end
         rrts_pkg::S_FINISH: begin
            if (out_free) state_in = rrts_pkg::S_IDLE;
         end
         default: state_in = rrts_pkg::S_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         rrts_pkg::S_IDLE: begin
            cmd.ld_req  = accept;
            cmd.res_clr = accept;
         end
         rrts_pkg::S_DECODE: begin
            unique case (stat.kind)
               rrts_pkg::KIND_ALLOC: begin
                  cmd.idx_clr = 1'b1;
               end
               rrts_pkg::KIND_FREE: begin
                  cmd.addr_ld  = stat.slot_ok;
                  cmd.addr_sel = rrts_pkg::ADDR_REQ;
               end
               rrts_pkg::KIND_ADD_READY: begin
                  cmd.addr_ld  = stat.slot_ok && !stat.rdy_full;
                  cmd.addr_sel = rrts_pkg::ADDR_REQ;
                  cmd.res_full = stat.slot_ok && stat.rdy_full;
               end
               rrts_pkg::KIND_YIELD: begin
                  cmd.addr_ld  = stat.run_valid;
                  cmd.addr_sel = rrts_pkg::ADDR_RUN;
               end
               rrts_pkg::KIND_SLEEP: begin
                  cmd.addr_ld   = stat.run_valid && !stat.slp_full;
                  cmd.addr_sel  = rrts_pkg::ADDR_RUN;
                  cmd.div_start = stat.run_valid && !stat.slp_full;
                  cmd.res_full  = stat.run_valid && stat.slp_full;
               end
               rrts_pkg::KIND_WAKE_CHECK: begin
                  cmd.res_done = !stat.slp_empty;
                  cmd.n_ld     = !stat.slp_empty;
               end
               default: begin
                  cmd.addr_ld = 1'b0;
               end
            endcase
         end
         rrts_pkg::S_A_ADDR: begin
            cmd.addr_ld  = 1'b1;
            cmd.addr_sel = rrts_pkg::ADDR_IDX;
         end
         rrts_pkg::S_A_READ: cmd.tbl_rd = 1'b1;
         rrts_pkg::S_A_CHECK: begin
            if (stat.q_free) begin
               cmd.tbl_wr    = 1'b1;
               cmd.wr_status = rrts_pkg::SLOT_READY;
               cmd.wr_pid    = rrts_pkg::PID_NEXT;
               cmd.wr_wake   = rrts_pkg::WAKE_ZERO;
               cmd.nid_inc   = 1'b1;
               cmd.res_done  = 1'b1;
               cmd.res_alloc = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         rrts_pkg::S_F_READ: cmd.tbl_rd = 1'b1;
         rrts_pkg::S_F_WRITE: begin
            cmd.tbl_wr    = 1'b1;
            cmd.wr_status = rrts_pkg::SLOT_FREE;
            cmd.wr_pid    = rrts_pkg::PID_ZERO;
            cmd.wr_wake   = rrts_pkg::WAKE_KEEP;
            cmd.res_done  = 1'b1;
         end
         rrts_pkg::S_R_READ: cmd.tbl_rd = 1'b1;
         rrts_pkg::S_R_WRITE: begin
            cmd.tbl_wr    = 1'b1;
            cmd.wr_status = rrts_pkg::SLOT_READY;
            cmd.wr_pid    = rrts_pkg::PID_KEEP;
            cmd.wr_wake   = rrts_pkg::WAKE_KEEP;
            cmd.rdy_push  = 1'b1;
            cmd.res_done  = 1'b1;
         end
         rrts_pkg::S_D_POP: begin
            cmd.addr_ld  = 1'b1;
            cmd.addr_sel = rrts_pkg::ADDR_RDY;
            cmd.rdy_pop  = 1'b1;
         end
         rrts_pkg::S_D_READ: cmd.tbl_rd = 1'b1;
         rrts_pkg::S_D_WRITE: begin
            cmd.tbl_wr    = 1'b1;
            cmd.wr_status = rrts_pkg::SLOT_RUNNING;
            cmd.wr_pid    = rrts_pkg::PID_KEEP;
            cmd.wr_wake   = rrts_pkg::WAKE_KEEP;
            cmd.run_set   = 1'b1;
            cmd.res_done  = 1'b1;
            cmd.res_slot  = 1'b1;
         end
         rrts_pkg::S_Y_READ: cmd.tbl_rd = 1'b1;
         rrts_pkg::S_Y_CHECK: begin
            if (stat.q_running) begin
               if (stat.rdy_full) begin
                  cmd.res_full = 1'b1;
               end else begin
                  cmd.tbl_wr    = 1'b1;
                  cmd.wr_status = rrts_pkg::SLOT_READY;
                  cmd.wr_pid    = rrts_pkg::PID_KEEP;
                  cmd.wr_wake   = rrts_pkg::WAKE_KEEP;
                  cmd.rdy_push  = 1'b1;
                  cmd.res_done  = 1'b1;
               end
            end
         end
         rrts_pkg::S_S_DIV: cmd.div_step = 1'b1;
         rrts_pkg::S_S_READ: cmd.tbl_rd = 1'b1;
         rrts_pkg::S_S_WRITE: begin
            cmd.tbl_wr    = 1'b1;
            cmd.wr_status = rrts_pkg::SLOT_SLEEPING;
            cmd.wr_pid    = rrts_pkg::PID_KEEP;
            cmd.wr_wake   = rrts_pkg::WAKE_CALC;
            cmd.slp_push  = 1'b1;
            cmd.res_done  = 1'b1;
            cmd.run_clr   = stat.rdy_empty;
         end
         rrts_pkg::S_W_POP: begin
            cmd.addr_ld  = 1'b1;
            cmd.addr_sel = rrts_pkg::ADDR_SLP;
            cmd.slp_pop  = 1'b1;
         end
         rrts_pkg::S_W_READ: cmd.tbl_rd = 1'b1;
         rrts_pkg::S_W_CHECK: begin
            cmd.n_dec = 1'b1;
            if (stat.q_due && !stat.rdy_full) begin
               cmd.tbl_wr    = 1'b1;
               cmd.wr_status = rrts_pkg::SLOT_READY;
               cmd.wr_pid    = rrts_pkg::PID_KEEP;
               cmd.wr_wake   = rrts_pkg::WAKE_KEEP;
               cmd.rdy_push  = 1'b1;
               cmd.woken_inc = 1'b1;
            end else begin
               cmd.slp_push = 1'b1;
               cmd.res_full = stat.q_due;
            end
         end
         rrts_pkg::S_FINISH: cmd.out_ld = out_free;
         default: cmd.out_ld = 1'b0;
      endcase
   end

   // Result channel valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == rrts_pkg::S_FINISH && out_free) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrts_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == rrts_pkg::S_DECODE)
      else $error("accepted item not decoded");
   a_valid_drops_on_take: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_ready))
      else $error("result dropped before taken");
   a_div_in_sleep: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> $past(state_ff == rrts_pkg::S_DECODE || state_ff == rrts_pkg::S_S_DIV))
      else $error("divider stepped outside sleep");

endmodule

// ----- hdl/round_robin_task_scheduler.sv -----
// Top level of the round-robin task scheduler: controller plus datapath.
// Depends on rrts_pkg, rrts_ctrl and rrts_datapath.
//
// One command item is worked at a time; the next is taken once the current
// one has moved to the result register, even while that result waits.
// Allocate scans up to all 16 slots in order, one slot table read per slot;
// sleep runs the 32-step shift-subtract divider and then dispatches the
// next ready task, if any; wake check makes one table read per sleeper.
// The slot table comes out of reset as all free with no clearing pass.
module round_robin_task_scheduler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rrts_pkg::KIND_W-1:0]      req_kind,
   input  logic [rrts_pkg::PORT_SLOT_W-1:0] req_slot,
   input  logic [rrts_pkg::MS_W-1:0]        req_milliseconds,
   input  logic [rrts_pkg::TICK_W-1:0]      req_now,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rrts_pkg::STAT_W-1:0]      rsp_status,
   output logic [rrts_pkg::PORT_SLOT_W-1:0] rsp_result_slot,
   output logic [rrts_pkg::PID_W-1:0]       rsp_result_pid,
   output logic                             rsp_running_valid,
   output logic [rrts_pkg::PORT_SLOT_W-1:0] rsp_running_slot,
   output logic [rrts_pkg::WOKEN_W-1:0]     rsp_woken_count,
   input  logic                             csr_wr_en,
   input  logic [rrts_pkg::DIVR_W-1:0]      csr_wr_data
);

   rrts_pkg::dp_cmd_type  cmd;
   rrts_pkg::dp_stat_type stat;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrts_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_slot          (req_slot),
      .req_milliseconds  (req_milliseconds),
      .req_now           (req_now),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_status        (rsp_status),
      .rsp_result_slot   (rsp_result_slot),
      .rsp_result_pid    (rsp_result_pid),
      .rsp_running_valid (rsp_running_valid),
      .rsp_running_slot  (rsp_running_slot),
      .rsp_woken_count   (rsp_woken_count)
   );

endmodule

// ----- tb/sv/tb_round_robin_task_scheduler.sv -----
// Testbench for round_robin_task_scheduler: directed and random command items
// checked against an in-bench scheduler model. Depends on rrts_pkg and the RTL.
module tb_round_robin_task_scheduler;

   localparam logic [rrts_pkg::KIND_W-1:0] KIND_UNKNOWN = 3'd7;
   localparam int QDEPTH      = 16;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int TOTAL_ITEMS = 1850;

   typedef struct {
      logic [rrts_pkg::STAT_W-1:0]      status;
      logic [rrts_pkg::PORT_SLOT_W-1:0] slot;
      logic [rrts_pkg::PID_W-1:0]       pid;
      logic                             run_valid;
      logic [rrts_pkg::PORT_SLOT_W-1:0] run_slot;
      logic [rrts_pkg::WOKEN_W-1:0]     woken;
   } sched_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [rrts_pkg::KIND_W-1:0] req_kind = '0;
   logic [rrts_pkg::PORT_SLOT_W-1:0] req_slot = '0;
   logic [rrts_pkg::MS_W-1:0] req_milliseconds = '0;
   logic [rrts_pkg::TICK_W-1:0] req_now = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [rrts_pkg::STAT_W-1:0] rsp_status;
   logic [rrts_pkg::PORT_SLOT_W-1:0] rsp_result_slot;
   logic [rrts_pkg::PID_W-1:0] rsp_result_pid;
   logic rsp_running_valid;
   logic [rrts_pkg::PORT_SLOT_W-1:0] rsp_running_slot;
   logic [rrts_pkg::WOKEN_W-1:0] rsp_woken_count;
   logic csr_wr_en = 1'b0;
   logic [rrts_pkg::DIVR_W-1:0] csr_wr_data = '0;

   // model of the scheduler state
   rrts_pkg::slot_state_type    mdl_status [rrts_pkg::NUM_SLOTS];
   logic [rrts_pkg::PID_W-1:0]  mdl_pid    [rrts_pkg::NUM_SLOTS];
   logic [rrts_pkg::TICK_W-1:0] mdl_wake   [rrts_pkg::NUM_SLOTS];
   logic [rrts_pkg::PID_W-1:0]  mdl_next_id;
   logic [3:0]                  mdl_ready_q [$];
   logic [3:0]                  mdl_sleep_q [$];
   logic                        mdl_run_valid;
   logic [3:0]                  mdl_run_slot;
   logic [rrts_pkg::DIVR_W-1:0] mdl_ms_per_tick;

   sched_result_type pending_results [$];
   int  error_count = 0;
   int  items_sent = 0;
   int  cycle_count = 0;
   bit  quiet_mode = 0;
   int  hold_request = 0;
   int  hold_count = 0;
   int  stall_count = 0;
   logic [rrts_pkg::TICK_W-1:0] tick_base = '0;

   round_robin_task_scheduler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_slot(req_slot),
      .req_milliseconds(req_milliseconds), .req_now(req_now),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_result_slot(rsp_result_slot),
      .rsp_result_pid(rsp_result_pid), .rsp_running_valid(rsp_running_valid),
      .rsp_running_slot(rsp_running_slot), .rsp_woken_count(rsp_woken_count),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // advance the scheduler model by one command and return its result
   function automatic sched_result_type schedule_step(
         logic [rrts_pkg::KIND_W-1:0] kind, logic [3:0] slot,
         logic [rrts_pkg::MS_W-1:0] ms, logic [rrts_pkg::TICK_W-1:0] now);
      sched_result_type r;
      logic [31:0] div;
      logic [33:0] wake;
      logic [3:0]  s;
      logic [3:0]  cur;
      int n;
      r.status = rrts_pkg::RES_NONE;
      r.slot = '0;
      r.pid = '0;
      r.woken = '0;
      case (kind)
         rrts_pkg::KIND_ALLOC: begin
            for (int i = 0; i < rrts_pkg::NUM_SLOTS; i++) begin
               if (mdl_status[i] == rrts_pkg::SLOT_FREE) begin
                  mdl_status[i] = rrts_pkg::SLOT_READY;
                  mdl_pid[i] = mdl_next_id;
                  mdl_wake[i] = '0;
                  mdl_next_id = mdl_next_id + 1'b1;
                  r.status = rrts_pkg::RES_DONE;
                  r.slot = 4'(i);
                  r.pid = mdl_pid[i];
                  break;
               end
            end
         end
         rrts_pkg::KIND_FREE: begin
            mdl_status[slot] = rrts_pkg::SLOT_FREE;
            mdl_pid[slot] = '0;
            r.status = rrts_pkg::RES_DONE;
         end
         rrts_pkg::KIND_ADD_READY: begin
            if (mdl_ready_q.size() < QDEPTH) begin
               mdl_ready_q.push_back(slot);
               mdl_status[slot] = rrts_pkg::SLOT_READY;
               r.status = rrts_pkg::RES_DONE;
            end else begin
               r.status = rrts_pkg::RES_FULL;
            end
         end
         rrts_pkg::KIND_DISPATCH: begin
            if (mdl_ready_q.size() != 0) begin
               s = mdl_ready_q.pop_front();
               mdl_run_valid = 1'b1;
               mdl_run_slot = s;
               mdl_status[s] = rrts_pkg::SLOT_RUNNING;
               r.status = rrts_pkg::RES_DONE;
               r.slot = s;
               r.pid = mdl_pid[s];
            end
         end
         rrts_pkg::KIND_YIELD: begin
            if (mdl_run_valid && mdl_status[mdl_run_slot] == rrts_pkg::SLOT_RUNNING) begin
               if (mdl_ready_q.size() < QDEPTH) begin
                  mdl_ready_q.push_back(mdl_run_slot);
                  mdl_status[mdl_run_slot] = rrts_pkg::SLOT_READY;
                  r.status = rrts_pkg::RES_DONE;
               end else begin
                  r.status = rrts_pkg::RES_FULL;
               end
            end
         end
         rrts_pkg::KIND_SLEEP: begin
            if (mdl_run_valid) begin
               div = (mdl_ms_per_tick == 0) ? 32'd1 : 32'(mdl_ms_per_tick);
               wake = 34'(now) + 34'(ms / div) + ((ms % div) != 0 ? 34'd1 : 34'd0);
               if (wake > 34'hFFFF_FFFF) wake = 34'hFFFF_FFFF;
               cur = mdl_run_slot;
               if (mdl_sleep_q.size() < QDEPTH) begin
                  mdl_sleep_q.push_back(cur);
                  mdl_wake[cur] = wake[31:0];
                  mdl_status[cur] = rrts_pkg::SLOT_SLEEPING;
                  r.status = rrts_pkg::RES_DONE;
                  if (mdl_ready_q.size() != 0) begin
                     s = mdl_ready_q.pop_front();
                     mdl_run_slot = s;
                     mdl_status[s] = rrts_pkg::SLOT_RUNNING;
                     r.slot = s;
                     r.pid = mdl_pid[s];
                  end else begin
                     mdl_run_valid = 1'b0;
                     mdl_run_slot = '0;
                  end
               end else begin
                  r.status = rrts_pkg::RES_FULL;
               end
            end
         end
         rrts_pkg::KIND_WAKE_CHECK: begin
            if (mdl_sleep_q.size() != 0) begin
               n = mdl_sleep_q.size();
               r.status = rrts_pkg::RES_DONE;
               for (int i = 0; i < n; i++) begin
                  s = mdl_sleep_q.pop_front();
                  if (now >= mdl_wake[s] && mdl_ready_q.size() < QDEPTH) begin
                     mdl_ready_q.push_back(s);
                     mdl_status[s] = rrts_pkg::SLOT_READY;
                     r.woken = r.woken + 1'b1;
                  end else begin
                     if (now >= mdl_wake[s]) r.status = rrts_pkg::RES_FULL;
                     mdl_sleep_q.push_back(s);
                  end
               end
            end
         end
         default: ;
      endcase
      r.run_valid = mdl_run_valid;
      r.run_slot = mdl_run_valid ? mdl_run_slot : 4'd0;
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h",
               cycle_count, field, got, want);
      error_count++;
   endtask

   function automatic int pick_gap();
      int roll;
      if (quiet_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // offer one command item and predict its result on acceptance
   task automatic send_item(logic [rrts_pkg::KIND_W-1:0] kind, logic [3:0] slot,
         logic [rrts_pkg::MS_W-1:0] ms, logic [rrts_pkg::TICK_W-1:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_kind = kind;
      req_slot = slot;
      req_milliseconds = ms;
      req_now = now;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(schedule_step(kind, slot, ms, now));
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_ms_per_tick(logic [rrts_pkg::DIVR_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      mdl_ms_per_tick = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [rrts_pkg::MS_W-1:0] rand_ms();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 20);
         1: return $urandom_range(0, 5000);
         2: return $urandom;
         default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      endcase
   endfunction

   function automatic logic [rrts_pkg::TICK_W-1:0] rand_now();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return tick_base + $urandom_range(0, 400);
   endfunction

   // field extremes, every command and the named corner cases
   task automatic test_directed();
      send_item(rrts_pkg::KIND_DISPATCH, 4'd0, '0, '0);
      send_item(rrts_pkg::KIND_YIELD, 4'd0, '0, '0);
      send_item(rrts_pkg::KIND_SLEEP, 4'd0, 32'd5, '0);
      send_item(rrts_pkg::KIND_WAKE_CHECK, 4'd0, '0, '0);
      send_item(rrts_pkg::KIND_ALLOC, 4'd0, '0, '0);
      send_item(rrts_pkg::KIND_ALLOC, 4'd0, '0, '0);
      send_item(rrts_pkg::KIND_ALLOC, 4'd0, '0, '0);
      send_item(rrts_pkg::KIND_ADD_READY, 4'd0, '0, '0);
      send_item(rrts_pkg::KIND_ADD_READY, 4'd1, '0, '0);
      send_item(rrts_pkg::KIND_ADD_READY, 4'd15, '0, '0);
      send_item(rrts_pkg::KIND_DISPATCH, 4'd0, '0, '0);
      send_item(rrts_pkg::KIND_YIELD, 4'd0, '0, '0);
      send_item(rrts_pkg::KIND_SLEEP, 4'd0, 32'd0, 32'd0);
      send_item(rrts_pkg::KIND_SLEEP, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(rrts_pkg::KIND_SLEEP, 4'd0, 32'd21, 32'd100);
      send_item(rrts_pkg::KIND_SLEEP, 4'd0, 32'd1, 32'd0);
      send_item(rrts_pkg::KIND_WAKE_CHECK, 4'd0, '0, 32'd50);
      send_item(rrts_pkg::KIND_WAKE_CHECK, 4'd0, '0, 32'hFFFF_FFFF);
      send_item(rrts_pkg::KIND_FREE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(rrts_pkg::KIND_FREE, 4'd0, '0, '0);
      send_item(KIND_UNKNOWN, 4'd9, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
      send_item(rrts_pkg::KIND_ADD_READY, 4'd0, '0, '0);
      send_item(rrts_pkg::KIND_DISPATCH, 4'd0, '0, '0);
   endtask

   // fill the slot table and the ready queue past their limits
   task automatic test_queue_limits();
      quiet_mode = 1;
      repeat (17) send_item(rrts_pkg::KIND_ALLOC, '0, '0, '0);
      for (int i = 0; i < 18; i++) send_item(rrts_pkg::KIND_ADD_READY, 4'(i), '0, '0);
      quiet_mode = 0;
      for (int i = 0; i < 18; i++) begin
         send_item(rrts_pkg::KIND_DISPATCH, '0, '0, '0);
         send_item(rrts_pkg::KIND_SLEEP, '0, 32'(i), 32'd1000);
      end
      send_item(rrts_pkg::KIND_WAKE_CHECK, '0, '0, 32'hFFFF_FFFF);
      send_item(rrts_pkg::KIND_WAKE_CHECK, '0, '0, 32'hFFFF_FFFF);
   endtask

   // stall the receiver while items keep coming, then pause until drained
   task automatic test_back_pressure();
      hold_request = 400;
      for (int i = 0; i < 12; i++) send_item(3'($urandom_range(0, 6)),
            4'($urandom), rand_ms(), rand_now());
      wait_drained();
   endtask

   // well-formed task lifecycles with random content, plus noise
   task automatic test_random_flow(int count);
      int stop;
      int seq;
      stop = items_sent + count;
      while (items_sent < stop) begin
         quiet_mode = ($urandom_range(0, 9) == 0);
         seq = $urandom_range(0, 99);
         tick_base = tick_base + $urandom_range(0, 50);
         if (seq < 20) begin
            send_item(rrts_pkg::KIND_ALLOC, 4'($urandom), '0, '0);
            send_item(rrts_pkg::KIND_ADD_READY, 4'($urandom), '0, '0);
         end else if (seq < 45) begin
            send_item(rrts_pkg::KIND_DISPATCH, '0, '0, '0);
            repeat ($urandom_range(1, 3)) send_item(
                  $urandom_range(0, 1) ? rrts_pkg::KIND_YIELD : rrts_pkg::KIND_SLEEP,
                  4'($urandom), rand_ms(), rand_now());
         end else if (seq < 65) begin
            send_item(rrts_pkg::KIND_WAKE_CHECK, 4'($urandom), rand_ms(), rand_now());
         end else if (seq < 75) begin
            send_item(rrts_pkg::KIND_FREE, 4'($urandom), '0, '0);
         end else if (seq < 80) begin
            repeat ($urandom_range(14, 20))
               send_item(rrts_pkg::KIND_ADD_READY, 4'($urandom), '0, '0);
         end else begin
            send_item(3'($urandom), 4'($urandom), $urandom, $urandom);
         end
      end
      quiet_mode = 0;
   endtask

   // receiver: long hold-offs on request, otherwise random stalls
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_count = hold_request;
         hold_request = 0;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp_ready = 1'b0;
      end else if (stall_count > 0) begin
         stall_count--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = 1'b1;
         if (!quiet_mode && $urandom_range(0, 7) == 0)
            stall_count = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                      : $urandom_range(1, 3);
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_result_slot !== want.slot)
               report_mismatch("result_slot", rsp_result_slot, want.slot);
            if (rsp_result_pid !== want.pid)
               report_mismatch("result_pid", rsp_result_pid, want.pid);
            if (rsp_running_valid !== want.run_valid)
               report_mismatch("running_valid", rsp_running_valid, want.run_valid);
            if (rsp_running_slot !== want.run_slot)
               report_mismatch("running_slot", rsp_running_slot, want.run_slot);
            if (rsp_woken_count !== want.woken)
               report_mismatch("woken_count", rsp_woken_count, want.woken);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < rrts_pkg::NUM_SLOTS; i++) begin
         mdl_status[i] = rrts_pkg::SLOT_FREE;
         mdl_pid[i] = '0;
         mdl_wake[i] = '0;
      end
      mdl_next_id = rrts_pkg::PID_FIRST;
      mdl_run_valid = 1'b0;
      mdl_run_slot = '0;
      mdl_ms_per_tick = rrts_pkg::MS_PER_TICK_RST;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      write_ms_per_tick(10'd1);
      test_queue_limits();
      write_ms_per_tick(10'd1000);
      test_back_pressure();
      test_random_flow(400);
      write_ms_per_tick(10'd0);
      test_random_flow(300);
      write_ms_per_tick(10'($urandom_range(2, 999)));
      test_random_flow(TOTAL_ITEMS - items_sent - 400);
      write_ms_per_tick(10'd1023);
      test_random_flow(400);

      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/rrts_pkg.sv
hdl/rrts_fifo.sv
hdl/rrts_div.sv
hdl/rrts_datapath.sv
hdl/rrts_ctrl.sv
hdl/round_robin_task_scheduler.sv
tb/sv/tb_round_robin_task_scheduler.sv
